FILE: hdl/rpn_stack_calculator_assert.svh
// assertion macros for the rpn stack calculator
// used by the top level only
`ifndef RPN_STACK_CALCULATOR_ASSERT_SVH
`define RPN_STACK_CALCULATOR_ASSERT_SVH
`ifndef ASSERT_OFF
`define RPN_ASSERT_IMPL(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
`define RPN_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define RPN_ASSERT_IMPL(label, clk, rst, a, c)
`define RPN_ASSERT_NEXT(label, clk, rst, a, c)
`endif
`endif

FILE: hdl/rpn_pkg.sv
// package for the rpn stack calculator: command and status codes, types
// no dependencies
`default_nettype none
package rpn_pkg;
  localparam int unsigned CMD_W = 4;
  localparam int unsigned STAT_W = 3;
  localparam int unsigned DATA_W = 32;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH = 4'd0, CMD_TOP = 4'd1, CMD_LIST = 4'd2, CMD_CLEAR = 4'd3,
    CMD_ADD = 4'd4, CMD_SUB = 4'd5, CMD_MUL = 4'd6, CMD_DIV = 4'd7,
    CMD_SWAP = 4'd8, CMD_NEG = 4'd9, CMD_DUP = 4'd10
  } cmd_t;

  localparam logic [STAT_W-1:0] ST_VALUE = 3'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 3'd1;
  localparam logic [STAT_W-1:0] ST_OPERANDS = 3'd2;
  localparam logic [STAT_W-1:0] ST_DIVZERO = 3'd3;
  localparam logic [STAT_W-1:0] ST_FULL = 3'd4;

  // classified request passed from front to back
  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [DATA_W-1:0] value;
  } req_t;
endpackage
`default_nettype wire

FILE: hdl/rpn_if.sv
// valid/ready channel interfaces for the rpn stack calculator
// no dependencies
`default_nettype none
interface rpn_in_if;
  logic valid;
  logic ready;
  logic [3:0] command;
  logic signed [31:0] push_value;
  modport source (output valid, command, push_value, input ready);
  modport sink (input valid, command, push_value, output ready);
endinterface

interface rpn_out_if;
  logic valid;
  logic ready;
  logic [2:0] status;
  logic signed [31:0] shown_value;
  logic last;
  modport source (output valid, status, shown_value, last, input ready);
  modport sink (input valid, status, shown_value, last, output ready);
endinterface
`default_nettype wire

FILE: hdl/rpn_stack_calculator.sv
// Top level of the rpn stack calculator: front queue feeding the back sequencer.
// The back end handles one command at a time; a 2-entry queue absorbs input.
// Division uses a restoring divider, one quotient bit per cycle; list reads each entry from the ram.
// Synchronous active-high reset empties the stack and queue; ram is not cleared.
`default_nettype none
`include "rpn_stack_calculator_assert.svh"
module rpn_stack_calculator #(
  parameter int unsigned STACK_DEPTH = 32
) (
  input wire logic clk,
  input wire logic rst,
  rpn_in_if.sink   cmd_in,
  rpn_out_if.source res
);
  import rpn_pkg::*;
  req_t req;
  logic req_valid, req_ready;
  logic [$clog2(STACK_DEPTH+1)-1:0] count;

  rpn_front u_front (
    .clk(clk), .rst(rst), .cmd_in(cmd_in),
    .req(req), .req_valid(req_valid), .req_ready(req_ready)
  );

  rpn_back #(.STACK_DEPTH(STACK_DEPTH)) u_back (
    .clk(clk), .rst(rst), .req(req), .req_valid(req_valid),
    .req_ready(req_ready), .res(res), .count_o(count)
  );

  // stack count never exceeds the depth
  `RPN_ASSERT_IMPL(a_count_range, clk, rst, 1'b1, count <= STACK_DEPTH)
  // results other than value always show zero
  `RPN_ASSERT_IMPL(a_zero_value, clk, rst, res.valid && res.status != ST_VALUE,
    res.shown_value == '0 && res.last)
  // clear empties the stack
  `RPN_ASSERT_NEXT(a_clear, clk, rst, req_valid && req_ready && req.cmd == CMD_CLEAR,
    count == '0)
endmodule
`default_nettype wire

FILE: hdl/rpn_ram.sv
// generic single-port-write, one-read ram with registered read
// no dependencies
`default_nettype none
module rpn_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

FILE: hdl/rpn_front.sv
// front end: accepts commands, drops unused codes, two-entry request queue
// depends on rpn_pkg and rpn_if
`default_nettype none
module rpn_front (
  input  wire logic         clk,
  input  wire logic         rst,
  rpn_in_if.sink            cmd_in,
  output rpn_pkg::req_t     req,
  output logic              req_valid,
  input  wire logic         req_ready
);
  import rpn_pkg::*;
  req_t q [2];
  logic [1:0] cnt;
  logic rd_ptr, wr_ptr;
  logic push, pop, legal;

  assign legal = (cmd_in.command <= CMD_DUP);
  assign cmd_in.ready = (cnt != 2'd2);
  assign push = cmd_in.valid && cmd_in.ready && legal;
  assign req_valid = (cnt != 2'd0);
  assign pop = req_valid && req_ready;
  assign req = q[rd_ptr];

  // queue storage and pointers
  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr].cmd <= cmd_in.command;
      q[wr_ptr].value <= cmd_in.push_value;
    end
    if (rst) begin
      cnt <= '0;
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end
endmodule
`default_nettype wire

FILE: hdl/rpn_back.sv
// back end: stack memory, sequencer, iterative divider, result register
// depends on rpn_pkg, rpn_if and rpn_ram
`default_nettype none
module rpn_back #(
  parameter int unsigned STACK_DEPTH = 32
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  rpn_pkg::req_t     req,
  input  wire logic         req_valid,
  output logic              req_ready,
  rpn_out_if.source         res,
  output logic [$clog2(STACK_DEPTH+1)-1:0] count_o
);
  import rpn_pkg::*;
  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam logic [CW-1:0] FULL = CW'(STACK_DEPTH);

  typedef enum logic [3:0] {
    S_IDLE, S_RD1, S_RD2, S_WAITB, S_EXEC, S_DIV, S_WR2, S_LIST, S_LISTW, S_OUT
  } state_t;

  state_t state;
  logic [CW-1:0] count;
  logic [CMD_W-1:0] cmd;
  logic [DATA_W-1:0] a, b, rdata, wdata, quo, rem, ma, mb;
  logic [AW-1:0] raddr, waddr;
  logic we, neg_q;
  logic [5:0] div_i;
  logic [CW-1:0] idx;
  logic [DATA_W:0] trial;
  logic [DATA_W-1:0] prod;
  logic [DATA_W-1:0] pend_wdata;
  logic [AW-1:0] pend_waddr;
  logic out_valid, out_last;
  logic [STAT_W-1:0] out_status;
  logic [DATA_W-1:0] out_value;

  rpn_ram #(.WIDTH(DATA_W), .DEPTH(STACK_DEPTH)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign count_o = count;
  assign req_ready = (state == S_IDLE) && !out_valid;
  assign res.valid = out_valid;
  assign res.status = out_status;
  assign res.shown_value = out_value;
  assign res.last = out_last;
  assign trial = {rem[DATA_W-2:0], ma[DATA_W-1]} - {1'b0, mb};
  assign prod = a * b;

  // main sequencer
  always_ff @(posedge clk) begin
    we <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && res.ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (req_valid && !out_valid) begin
            cmd <= req.cmd;
            out_last <= 1'b1;
            out_value <= '0;
            unique case (req.cmd) inside
              CMD_PUSH: begin
                if (count == FULL) begin
                  out_status <= ST_FULL; out_valid <= 1'b1;
                end else begin
                  we <= 1'b1; waddr <= AW'(count); wdata <= req.value;
                  count <= count + 1'b1;
                end
              end
              CMD_CLEAR: count <= '0;
              CMD_TOP, CMD_NEG: begin
                if (count == '0) begin
                  out_status <= ST_OPERANDS; out_valid <= 1'b1;
                end else begin
                  raddr <= AW'(count - 1'b1); state <= S_RD1;
                end
              end
              CMD_DUP: begin
                if (count == '0) begin
                  out_status <= ST_OPERANDS; out_valid <= 1'b1;
                end else if (count == FULL) begin
                  out_status <= ST_FULL; out_valid <= 1'b1;
                end else begin
                  raddr <= AW'(count - 1'b1); state <= S_RD1;
                end
              end
              CMD_LIST: begin
                if (count == '0) begin
                  out_status <= ST_EMPTY; out_valid <= 1'b1;
                end else begin
                  idx <= count; raddr <= AW'(count - 1'b1); state <= S_LIST;
                end
              end
              default: begin
                if (count < CW'(2)) begin
                  out_status <= ST_OPERANDS; out_valid <= 1'b1;
                end else begin
                  raddr <= AW'(count - 2'd2); state <= S_RD1;
                end
              end
            endcase
          end
        end
        S_RD1: begin
          raddr <= AW'(count - 1'b1); state <= S_RD2;
        end
        S_RD2: begin
          a <= rdata; state <= S_WAITB;
        end
        S_WAITB: begin
          if (cmd == CMD_TOP || cmd == CMD_NEG || cmd == CMD_DUP) begin
            b <= a; state <= S_EXEC;
          end else begin
            b <= rdata; state <= S_EXEC;
          end
        end
        S_EXEC: begin
          state <= S_IDLE;
          unique case (cmd) inside
            CMD_TOP: begin
              out_status <= ST_VALUE; out_value <= b; out_valid <= 1'b1;
            end
            CMD_NEG: begin
              we <= 1'b1; waddr <= AW'(count - 1'b1); wdata <= '0 - b;
            end
            CMD_DUP: begin
              we <= 1'b1; waddr <= AW'(count); wdata <= b; count <= count + 1'b1;
            end
            CMD_ADD, CMD_SUB, CMD_MUL: begin
              we <= 1'b1; waddr <= AW'(count - 2'd2); count <= count - 1'b1;
              wdata <= (cmd == CMD_ADD) ? a + b : (cmd == CMD_SUB) ? a - b : prod;
            end
            CMD_SWAP: begin
              we <= 1'b1; waddr <= AW'(count - 2'd2); wdata <= b;
              pend_waddr <= AW'(count - 1'b1); pend_wdata <= a; state <= S_WR2;
            end
            default: begin
              if (b == '0) begin
                out_status <= ST_DIVZERO; out_valid <= 1'b1;
              end else begin
                ma <= a[DATA_W-1] ? '0 - a : a;
                mb <= b[DATA_W-1] ? '0 - b : b;
                neg_q <= a[DATA_W-1] ^ b[DATA_W-1];
                rem <= '0; quo <= '0; div_i <= '0; state <= S_DIV;
              end
            end
          endcase
        end
        S_DIV: begin
          // one restoring step per cycle
          ma <= {ma[DATA_W-2:0], 1'b0};
          if (!trial[DATA_W]) begin
            rem <= trial[DATA_W-1:0]; quo <= {quo[DATA_W-2:0], 1'b1};
          end else begin
            rem <= {rem[DATA_W-2:0], ma[DATA_W-1]}; quo <= {quo[DATA_W-2:0], 1'b0};
          end
          div_i <= div_i + 1'b1;
          if (div_i == 6'(DATA_W - 1)) state <= S_OUT;
        end
        S_OUT: begin
          we <= 1'b1; waddr <= AW'(count - 2'd2); count <= count - 1'b1;
          wdata <= neg_q ? '0 - quo : quo; state <= S_IDLE;
        end
        S_WR2: begin
          we <= 1'b1; waddr <= pend_waddr; wdata <= pend_wdata; state <= S_IDLE;
        end
        S_LIST: begin
          // read latency slot
          state <= S_LISTW;
        end
        S_LISTW: begin
          if (!out_valid || res.ready) begin
            out_status <= ST_VALUE; out_value <= rdata;
            out_last <= (idx == CW'(1)); out_valid <= 1'b1;
            if (idx == CW'(1)) begin
              state <= S_IDLE;
            end else begin
              idx <= idx - 1'b1; raddr <= AW'(idx - 2'd2); state <= S_LIST;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: bench/tb_rpn_scoreboard.sv
// scoreboard for the rpn stack calculator: stack predictor and expected-result queue
// depends on rpn_pkg
`timescale 1ns / 1ps
class rpn_scoreboard;
  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] shown;
    logic        last;
  } calc_result_t;

  logic [31:0] stack_words[32];
  int unsigned depth_used;
  calc_result_t pending_results[$];
  int unsigned error_count;

  function new();
    depth_used = 0;
    error_count = 0;
  endfunction

  function void expect_one(logic [2:0] st, logic [31:0] v, logic lst);
    calc_result_t r;
    r.status = st;
    r.shown = v;
    r.last = lst;
    pending_results.push_back(r);
  endfunction

  function logic [31:0] div_trunc(logic [31:0] a, logic [31:0] b);
    logic [31:0] ma;
    logic [31:0] mb;
    logic [31:0] q;
    ma = a[31] ? -a : a;
    mb = b[31] ? -b : b;
    q = ma / mb;
    return (a[31] ^ b[31]) ? -q : q;
  endfunction

  // apply one accepted request to the predicted stack
  function void note_request(logic [3:0] cmd, logic [31:0] val);
    logic [31:0] a;
    logic [31:0] b;
    int unsigned n;
    n = depth_used;
    case (cmd)
      rpn_pkg::CMD_PUSH: begin
        if (n >= 32) expect_one(rpn_pkg::ST_FULL, 0, 1);
        else begin
          stack_words[n] = val;
          depth_used = n + 1;
        end
      end
      rpn_pkg::CMD_TOP: begin
        if (n == 0) expect_one(rpn_pkg::ST_OPERANDS, 0, 1);
        else expect_one(rpn_pkg::ST_VALUE, stack_words[n-1], 1);
      end
      rpn_pkg::CMD_LIST: begin
        if (n == 0) expect_one(rpn_pkg::ST_EMPTY, 0, 1);
        else for (int i = n; i > 0; i--) expect_one(rpn_pkg::ST_VALUE, stack_words[i-1], i == 1);
      end
      rpn_pkg::CMD_CLEAR: depth_used = 0;
      rpn_pkg::CMD_ADD, rpn_pkg::CMD_SUB, rpn_pkg::CMD_MUL, rpn_pkg::CMD_DIV,
      rpn_pkg::CMD_SWAP: begin
        if (n < 2) expect_one(rpn_pkg::ST_OPERANDS, 0, 1);
        else begin
          a = stack_words[n-2];
          b = stack_words[n-1];
          if (cmd == rpn_pkg::CMD_SWAP) begin
            stack_words[n-2] = b;
            stack_words[n-1] = a;
          end else if (cmd == rpn_pkg::CMD_DIV && b == 0) begin
            expect_one(rpn_pkg::ST_DIVZERO, 0, 1);
          end else begin
            case (cmd)
              rpn_pkg::CMD_ADD: a = a + b;
              rpn_pkg::CMD_SUB: a = a - b;
              rpn_pkg::CMD_MUL: a = a * b;
              default: a = div_trunc(a, b);
            endcase
            stack_words[n-2] = a;
            depth_used = n - 1;
          end
        end
      end
      rpn_pkg::CMD_NEG: begin
        if (n == 0) expect_one(rpn_pkg::ST_OPERANDS, 0, 1);
        else stack_words[n-1] = -stack_words[n-1];
      end
      rpn_pkg::CMD_DUP: begin
        if (n == 0) expect_one(rpn_pkg::ST_OPERANDS, 0, 1);
        else if (n >= 32) expect_one(rpn_pkg::ST_FULL, 0, 1);
        else begin
          stack_words[n] = stack_words[n-1];
          depth_used = n + 1;
        end
      end
      default: ;
    endcase
  endfunction

  // compare one accepted result with the oldest expectation
  function void check_result(logic [2:0] st, logic [31:0] v, logic lst);
    calc_result_t e;
    if (pending_results.size() == 0) begin
      $error("unexpected result status=%0d value=%0d last=%0d", st, $signed(v), lst);
      error_count++;
      return;
    end
    e = pending_results.pop_front();
    if (st !== e.status) begin
      $error("status expected %0d actual %0d", e.status, st);
      error_count++;
    end
    if (v !== e.shown) begin
      $error("shown_value expected %0d actual %0d", $signed(e.shown), $signed(v));
      error_count++;
    end
    if (lst !== e.last) begin
      $error("last expected %0d actual %0d", e.last, lst);
      error_count++;
    end
  endfunction
endclass

FILE: bench/tb_top.sv
// top-level bench for rpn_stack_calculator: directed and random command streams
// depends on rpn_pkg, rpn_if, tb_rpn_scoreboard and the block itself
`timescale 1ns / 1ps
module tb_top;
  import rpn_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  rpn_in_if cmd_ch ();
  rpn_out_if res_ch ();
  rpn_scoreboard board = new();
  bit hold_long = 0;
  bit stim_done = 0;

  rpn_stack_calculator DUT (.clk(clk), .rst(rst), .cmd_in(cmd_ch.sink), .res(res_ch.source));

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    cmd_ch.valid = 1'b0;
    cmd_ch.command = '0;
    cmd_ch.push_value = '0;
    res_ch.ready = 1'b0;
  end

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return 32'h0;
      4: return $urandom_range(0, 20) - 10;
      default: return $urandom;
    endcase
  endfunction

  // send one request and record it once accepted
  task automatic send_request(logic [3:0] cmd, logic [31:0] val, bit idle_ok = 1);
    int unsigned g;
    g = idle_ok ? gap_len() : 0;
    if (g > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.command <= cmd;
    cmd_ch.push_value <= val;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    board.note_request(cmd, val);
  endtask

  task automatic drain_results();
    cmd_ch.valid <= 1'b0;
    while (board.pending_results.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  // receiver: random stalls, one long hold-off on request
  initial begin
    int unsigned g;
    @(negedge rst);
    forever begin
      if (hold_long) begin
        res_ch.ready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_long = 0;
      end
      g = gap_len();
      if (g > 0) begin
        res_ch.ready <= 1'b0;
        repeat (g) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      @(posedge clk);
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready)
      board.check_result(res_ch.status, res_ch.shown_value, res_ch.last);
  end

  initial begin
    int unsigned n;
    logic [3:0] c;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed: empty-stack errors, extremes, every operation
    send_request(CMD_TOP, 0);
    send_request(CMD_LIST, 0);
    send_request(CMD_ADD, 0);
    send_request(CMD_NEG, 0);
    send_request(CMD_DUP, 0);
    send_request(CMD_PUSH, 32'h8000_0000);
    send_request(CMD_SWAP, 0);
    send_request(CMD_PUSH, 32'hffff_ffff);
    send_request(CMD_DIV, 0);
    send_request(CMD_TOP, 0);
    send_request(CMD_PUSH, 0);
    send_request(CMD_DIV, 0);
    send_request(CMD_PUSH, 32'h7fff_ffff);
    send_request(CMD_ADD, 0);
    send_request(CMD_PUSH, 32'hffff_fff9);
    send_request(CMD_MUL, 0);
    send_request(CMD_PUSH, 5);
    send_request(CMD_SUB, 0);
    send_request(CMD_NEG, 0);
    send_request(CMD_DUP, 0);
    send_request(CMD_LIST, 0);
    send_request(4'd15, 32'h5a5a_5a5a);
    send_request(CMD_CLEAR, 0);
    send_request(4'd11, 0);
    drain_results();
    // fill past full while receiver holds off, then list under pressure
    hold_long = 1;
    for (int i = 0; i < 33; i++) send_request(CMD_PUSH, $urandom, 0);
    send_request(CMD_DUP, 0, 0);
    send_request(CMD_LIST, 0, 0);
    send_request(CMD_LIST, 0, 0);
    drain_results();
    send_request(CMD_CLEAR, 0);
    // random: pushes most often, mixed with the other commands and unused codes
    n = 0;
    while (n < 110) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5: c = CMD_PUSH;
        6: c = CMD_TOP;
        7: c = CMD_LIST;
        8: c = ($urandom_range(0, 3) == 0) ? CMD_CLEAR : CMD_ADD;
        9: c = CMD_ADD;
        10: c = CMD_SUB;
        11: c = CMD_MUL;
        12, 13: c = CMD_DIV;
        14: c = CMD_SWAP;
        15: c = CMD_NEG;
        16, 17: c = CMD_DUP;
        default: c = 4'($urandom_range(0, 15));
      endcase
      send_request(c, pick_value());
      if (c <= CMD_DUP) n++;
    end
    cmd_ch.valid <= 1'b0;
    stim_done = 1;
  end

  // end of run
  initial begin
    wait (stim_done);
    while (board.pending_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (board.error_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  initial begin
    #4_000_000;
    $display("== FAIL ==");
    $finish;
  end
endmodule
